### hw/rtl/krct_pkg.sv
// ----------------------------------------------------------------------------
// krct_pkg
// Shared types and constants of the key reference count table.
// ----------------------------------------------------------------------------
package krct_pkg;

  // table geometry
  localparam int TableEntries = 16;
  localparam int KeyBits      = 64;
  localparam int IdxBits      = $clog2(TableEntries);
  localparam int HeldBits     = $clog2(TableEntries + 1);

  // field widths
  localparam int CmdBits      = 2;
  localparam int KeyFieldBits = 64;
  localparam int CountBits    = 32;
  localparam int OccBits      = 5;
  localparam int StatusBits   = 2;

  localparam logic [CountBits-1:0] CountMax = '1;

  // request commands
  typedef enum logic [CmdBits-1:0] {
    CmdPush   = 2'd0,
    CmdPop    = 2'd1,
    CmdRemove = 2'd2,
    CmdLookup = 2'd3
  } krct_cmd_e;

  // result status codes
  typedef enum logic [StatusBits-1:0] {
    StatusOk       = 2'd0,
    StatusPopMiss  = 2'd1,
    StatusPushFull = 2'd2
  } krct_status_e;

  // request payload
  typedef struct packed {
    krct_cmd_e               command;
    logic [KeyFieldBits-1:0] key;
  } krct_req_t;

  // result payload
  typedef struct packed {
    logic                 found;
    logic [CountBits-1:0] use_count;
    logic [OccBits-1:0]   occupancy;
    krct_status_e         status;
  } krct_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_req;
    logic do_match;
    logic do_apply;
  } krct_ctrl_t;

endpackage

### hw/rtl/krct_ctrl.sv
// ----------------------------------------------------------------------------
// krct_ctrl
// Sequencer: request capture, compare cycle, update cycle, result handoff.
// ----------------------------------------------------------------------------
module krct_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output krct_pkg::krct_ctrl_t ctrl_o
);
  import krct_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StMatch,
    StApply
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  // result slot is free when empty or being drained now
  assign out_free = !out_valid_q || out_ready_i;

  // a new request may enter while the previous one is written back
  assign in_ready_o      = (state_q == StIdle) || ((state_q == StApply) && out_free);
  assign ctrl_o.load_req = in_valid_i && in_ready_o;
  assign ctrl_o.do_match = (state_q == StMatch);
  assign ctrl_o.do_apply = (state_q == StApply) && out_free;
  assign out_valid_o     = out_valid_q;

  // state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (ctrl_o.load_req) state_q <= StMatch;
        end
        StMatch: begin
          state_q <= StApply;
        end
        StApply: begin
          if (out_free) state_q <= ctrl_o.load_req ? StMatch : StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase

      if (ctrl_o.do_apply) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/krct_datapath.sv
// ----------------------------------------------------------------------------
// krct_datapath
// Entry storage, parallel key compare, count update and result register.
// ----------------------------------------------------------------------------
module krct_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  krct_pkg::krct_ctrl_t ctrl_i,
  input  krct_pkg::krct_req_t  req_i,
  output krct_pkg::krct_rsp_t  rsp_o
);
  import krct_pkg::*;

  // captured request
  krct_cmd_e            req_cmd_q;
  logic [KeyBits-1:0]   req_key_q;

  // table state
  logic [TableEntries-1:0] valid_q;
  logic [KeyBits-1:0]      key_q   [TableEntries];
  logic [CountBits-1:0]    count_q [TableEntries];
  logic [HeldBits-1:0]     held_q, held_d;

  // compare results
  logic                hit_d, hit_q;
  logic [IdxBits-1:0]  hit_idx_d, hit_idx_q;
  logic                spare_d, spare_q;
  logic [IdxBits-1:0]  spare_idx_d, spare_idx_q;

  // update controls
  logic                 wr_en;
  logic [IdxBits-1:0]   wr_idx;
  logic [CountBits-1:0] wr_count;
  logic                 wr_key_en;
  logic                 set_valid;
  logic                 clr_valid;
  logic [CountBits-1:0] hit_count;
  krct_rsp_t            rsp_d, rsp_q;

  // request capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_req) begin
      req_cmd_q <= req_i.command;
      req_key_q <= req_i.key[KeyBits-1:0];
    end
  end

  // lowest matching entry and lowest free entry
  always_comb begin
    hit_d       = 1'b0;
    hit_idx_d   = '0;
    spare_d     = 1'b0;
    spare_idx_d = '0;
    for (int i = 0; i < TableEntries; i++) begin
      if (valid_q[i]) begin
        if (!hit_d && (key_q[i] == req_key_q)) begin
          hit_d     = 1'b1;
          hit_idx_d = IdxBits'(i);
        end
      end else if (!spare_d) begin
        spare_d     = 1'b1;
        spare_idx_d = IdxBits'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.do_match) begin
      hit_q       <= hit_d;
      hit_idx_q   <= hit_idx_d;
      spare_q     <= spare_d;
      spare_idx_q <= spare_idx_d;
    end
  end

  assign hit_count = count_q[hit_idx_q];

  // read-modify-write of the matched or free entry
  always_comb begin
    wr_en           = 1'b0;
    wr_idx          = hit_idx_q;
    wr_count        = hit_count;
    wr_key_en       = 1'b0;
    set_valid       = 1'b0;
    clr_valid       = 1'b0;
    held_d          = held_q;
    rsp_d.found     = hit_q;
    rsp_d.use_count = '0;
    rsp_d.status    = StatusOk;

    unique case (req_cmd_q)
      CmdPush: begin
        if (hit_q) begin
          wr_en           = 1'b1;
          wr_count        = (hit_count == CountMax) ? hit_count : hit_count + 1'b1;
          rsp_d.use_count = wr_count;
        end else if (spare_q) begin
          wr_en           = 1'b1;
          wr_idx          = spare_idx_q;
          wr_count        = CountBits'(1);
          wr_key_en       = 1'b1;
          set_valid       = 1'b1;
          held_d          = held_q + 1'b1;
          rsp_d.use_count = CountBits'(1);
        end else begin
          rsp_d.status = StatusPushFull;
        end
      end
      CmdPop: begin
        if (hit_q) begin
          wr_en           = 1'b1;
          wr_count        = (hit_count == '0) ? hit_count : hit_count - 1'b1;
          rsp_d.use_count = wr_count;
        end else begin
          rsp_d.status = StatusPopMiss;
        end
      end
      CmdRemove: begin
        if (hit_q) begin
          wr_en     = 1'b1;
          wr_count  = '0;
          clr_valid = 1'b1;
          if (held_q != '0) held_d = held_q - 1'b1;
        end
      end
      CmdLookup: begin
        if (hit_q) rsp_d.use_count = hit_count;
      end
      default: begin
        rsp_d.use_count = '0;
      end
    endcase

    rsp_d.occupancy = OccBits'(held_d);
  end

  // valid bits and key count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      held_q  <= '0;
    end else if (ctrl_i.do_apply) begin
      if (set_valid) valid_q[wr_idx] <= 1'b1;
      if (clr_valid) valid_q[wr_idx] <= 1'b0;
      held_q <= held_d;
    end
  end

  // entry payload and result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.do_apply) begin
      if (wr_en)     count_q[wr_idx] <= wr_count;
      if (wr_key_en) key_q[wr_idx]   <= req_key_q;
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

### hw/rtl/key_reference_count_table.sv
// ----------------------------------------------------------------------------
// key_reference_count_table: associative key table with per-key use counts
// a request is captured, compared, then applied to the matched or free entry
// by a read-modify-write into the result register, held while it is unread;
// the next request enters during the update; reset empties the table at once
// ----------------------------------------------------------------------------
module key_reference_count_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  krct_pkg::krct_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output krct_pkg::krct_rsp_t out_rsp_o
);
  import krct_pkg::*;

  krct_ctrl_t ctrl;

  // sequencer
  krct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  // table and result path
  krct_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .req_i  (in_req_i),
    .rsp_o  (out_rsp_o)
  );

endmodule
